>>> sv/d2p_pkg.sv
package d2p_pkg;

   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam int unsigned CSR_DATA_BITS  = 24;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRINCIPAL_X = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRINCIPAL_Y = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INV_FOCAL_X = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INV_FOCAL_Y = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_WIDTH  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_DEPTH   = 3'd5;

   localparam logic [15:0] RESET_PRINCIPAL_X = 16'd5112;
   localparam logic [15:0] RESET_PRINCIPAL_Y = 16'd3832;
   localparam logic [23:0] RESET_INV_FOCAL   = 24'd31957;
   localparam logic [12:0] RESET_LINE_WIDTH  = 13'd640;
   localparam logic [15:0] RESET_MIN_DEPTH   = 16'd100;

   localparam logic [15:0] INVALID_Z_MM = 16'd1000;
   localparam logic [11:0] COUNT_MAX    = 12'hFFF;
   localparam int unsigned FRAC_SHIFT   = 28;
   localparam int unsigned INV_SPLIT    = 12;

   typedef struct packed {
      logic [15:0] principal_x;
      logic [15:0] principal_y;
      logic [23:0] inv_focal_x;
      logic [23:0] inv_focal_y;
      logic [12:0] line_width;
      logic [15:0] min_depth_mm;
   } cfg_type;

   typedef struct packed {
      logic signed [17:0] dx;
      logic signed [17:0] dy;
      logic [15:0]        z_calc;
      logic               depth_valid;
      logic [7:0]         blue;
      logic [7:0]         green;
      logic [7:0]         red;
      logic [11:0]        column;
      logic [11:0]        row;
   } item_type;

endpackage

>>> sv/d2p_front.sv
module d2p_front #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  d2p_pkg::cfg_type   cfg,
   input  logic               accept,
   input  logic               frame_start,
   input  logic [15:0]        depth_mm,
   input  logic [7:0]         blue,
   input  logic [7:0]         green,
   input  logic [7:0]         red,
   output d2p_pkg::item_type  item
);

   logic [11:0] column_ff, column_in;
   logic [11:0] row_ff, row_in;
   logic [11:0] col_cur, row_cur;
   logic [12:0] width_eff;
   logic        wrap;
   logic        valid;

   assign col_cur = frame_start ? 12'd0 : column_ff;
   assign row_cur = frame_start ? 12'd0 : row_ff;

   always_comb begin
      if (cfg.line_width == 13'd0) begin
         width_eff = 13'd1;
      end else if (cfg.line_width > 13'(MAX_WIDTH)) begin
         width_eff = 13'(MAX_WIDTH);
      end else begin
         width_eff = cfg.line_width;
      end
   end

   assign wrap = ({1'b0, col_cur} + 13'd1) >= width_eff;

   always_comb begin
      if (wrap) begin
         column_in = 12'd0;
         row_in    = (row_cur == d2p_pkg::COUNT_MAX) ? row_cur : row_cur + 12'd1;
      end else begin
         column_in = col_cur + 12'd1;
         row_in    = row_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= 12'd0;
         row_ff    <= 12'd0;
      end else if (accept) begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

   assign valid = depth_mm > cfg.min_depth_mm;

   always_comb begin
      item.dx          = $signed({2'b00, col_cur, 4'b0000}) - $signed({2'b00, cfg.principal_x});
      item.dy          = $signed({2'b00, row_cur, 4'b0000}) - $signed({2'b00, cfg.principal_y});
      item.z_calc      = valid ? depth_mm : d2p_pkg::INVALID_Z_MM;
      item.depth_valid = valid;
      item.blue        = blue;
      item.green       = green;
      item.red         = red;
      item.column      = col_cur;
      item.row         = row_cur;
   end

endmodule

>>> sv/d2p_queue.sv
module d2p_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  d2p_pkg::item_type  wr_data,
   output logic               full,
   input  logic               rd_en,
   output d2p_pkg::item_type  rd_data,
   output logic               empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   d2p_pkg::item_type slot_ff [DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [AW:0]       count_ff, count_in;
   logic              do_wr, do_rd;

   assign full    = count_ff == (AW+1)'(DEPTH);
   assign empty   = count_ff == '0;
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (do_rd) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= (AW+1)'(DEPTH))
      else $error("queue count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      (do_wr && !do_rd) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count missed a write");

endmodule

>>> sv/d2p_back.sv
module d2p_back #(
   parameter int COORD_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  d2p_pkg::cfg_type              cfg,
   input  logic                          q_empty,
   input  d2p_pkg::item_type             q_data,
   output logic                          q_pop,
   input  logic                          pop,
   output logic                          empty,
   output logic signed [COORD_BITS-1:0]  x_mm,
   output logic signed [COORD_BITS-1:0]  y_mm,
   output logic [15:0]                   z_mm,
   output logic                          depth_valid,
   output logic [7:0]                    out_blue,
   output logic [7:0]                    out_green,
   output logic [7:0]                    out_red,
   output logic [11:0]                   pixel_column,
   output logic [11:0]                   pixel_row
);

   localparam int IS = d2p_pkg::INV_SPLIT;
   localparam logic signed [32:0] SAT_HI = 33'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
   localparam logic signed [32:0] SAT_LO = -SAT_HI - 33'sd1;

   logic                     en;
   logic                     v1_ff, v2_ff, v3_ff;
   d2p_pkg::item_type        it1_ff, it2_ff, it3_ff;
   logic signed [34:0]       ax_ff, ay_ff;
   logic signed [47:0]       xlo_ff, xhi_ff, ylo_ff, yhi_ff;
   logic signed [COORD_BITS-1:0] x_ff, y_ff, x_in, y_in;

   function automatic logic signed [COORD_BITS-1:0] shift_sat(
      input logic signed [47:0] lo,
      input logic signed [47:0] hi
   );
      logic signed [59:0] p;
      logic signed [32:0] q;
      logic signed [32:0] r;
      p = ($signed({{12{hi[47]}}, hi}) <<< IS) + $signed({{12{lo[47]}}, lo});
      q = 33'(p >>> d2p_pkg::FRAC_SHIFT);
      if (q > SAT_HI) begin
         r = SAT_HI;
      end else if (q < SAT_LO) begin
         r = SAT_LO;
      end else begin
         r = q;
      end
      return r[COORD_BITS-1:0];
   endfunction

   assign en    = !v3_ff || pop;
   assign q_pop = en && !q_empty;

   assign x_in = shift_sat(xlo_ff, xhi_ff);
   assign y_in = shift_sat(ylo_ff, yhi_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= !q_empty;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         it1_ff <= q_data;
         ax_ff  <= q_data.dx * $signed({1'b0, q_data.z_calc});
         ay_ff  <= q_data.dy * $signed({1'b0, q_data.z_calc});
         it2_ff <= it1_ff;
         xlo_ff <= ax_ff * $signed({1'b0, cfg.inv_focal_x[IS-1:0]});
         xhi_ff <= ax_ff * $signed({1'b0, cfg.inv_focal_x[23:IS]});
         ylo_ff <= ay_ff * $signed({1'b0, cfg.inv_focal_y[IS-1:0]});
         yhi_ff <= ay_ff * $signed({1'b0, cfg.inv_focal_y[23:IS]});
         it3_ff <= it2_ff;
         x_ff   <= x_in;
         y_ff   <= y_in;
      end
   end

   assign empty        = !v3_ff;
   assign x_mm         = x_ff;
   assign y_mm         = y_ff;
   assign z_mm         = it3_ff.depth_valid ? it3_ff.z_calc : 16'd0;
   assign depth_valid  = it3_ff.depth_valid;
   assign out_blue     = it3_ff.blue;
   assign out_green    = it3_ff.green;
   assign out_red      = it3_ff.red;
   assign pixel_column = it3_ff.column;
   assign pixel_row    = it3_ff.row;

   assert property (@(posedge clock) disable iff (reset)
      !en |=> ($stable(v1_ff) && $stable(v2_ff) && $stable(x_ff) && $stable(y_ff)))
      else $error("pipeline moved while stalled");

   assert property (@(posedge clock) disable iff (reset)
      (en && v2_ff) |=> v3_ff)
      else $error("word lost between stages");

   assert property (@(posedge clock) disable iff (reset)
      q_pop |=> v1_ff)
      else $error("popped word not captured");

   assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !it3_ff.depth_valid) |-> (it3_ff.z_calc == d2p_pkg::INVALID_Z_MM))
      else $error("invalid depth not replaced");

endmodule

>>> sv/depth_to_point_backprojection.sv
// Back-projects a raster-order depth stream into 3-D points, one word per pixel.
// Input side: drive req_* with push high; a word is taken on a clock edge where
// push is high and full is low. req_frame_start marks the first pixel of a frame.
// Result side: while empty is low the oldest point sits on rsp_*; pop high on an
// edge takes it. Every input word gives exactly one result word, in order.
// Each word passes through two multiply stages, then the shift-and-saturate output
// register. Throughput is one word per cycle while a low pop does not hold the
// back end.
// Config: csr_write_en writes csr_data into register csr_index on the edge;
// write only while no words are in flight. Unknown indexes are ignored.
// Reset (synchronous, active high) restores default calibration, clears the
// column and row counters and empties the queue and pipeline.
// When pop stays low the back end holds, the 4-entry queue fills, and full
// rises; no word is dropped.
module depth_to_point_backprojection #(
   parameter int MAX_WIDTH  = 4096,
   parameter int COORD_BITS = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  logic                                 req_frame_start,
   input  logic [15:0]                          req_depth_mm,
   input  logic [7:0]                           req_blue,
   input  logic [7:0]                           req_green,
   input  logic [7:0]                           req_red,
   output logic                                 empty,
   input  logic                                 pop,
   output logic signed [COORD_BITS-1:0]         rsp_x_mm,
   output logic signed [COORD_BITS-1:0]         rsp_y_mm,
   output logic [15:0]                          rsp_z_mm,
   output logic                                 rsp_depth_valid,
   output logic [7:0]                           rsp_out_blue,
   output logic [7:0]                           rsp_out_green,
   output logic [7:0]                           rsp_out_red,
   output logic [11:0]                          rsp_pixel_column,
   output logic [11:0]                          rsp_pixel_row,
   input  logic                                 csr_write_en,
   input  logic [d2p_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [d2p_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   d2p_pkg::cfg_type  cfg_ff;
   d2p_pkg::item_type front_item;
   d2p_pkg::item_type q_data;
   logic              accept;
   logic              q_full, q_empty, q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.principal_x  <= d2p_pkg::RESET_PRINCIPAL_X;
         cfg_ff.principal_y  <= d2p_pkg::RESET_PRINCIPAL_Y;
         cfg_ff.inv_focal_x  <= d2p_pkg::RESET_INV_FOCAL;
         cfg_ff.inv_focal_y  <= d2p_pkg::RESET_INV_FOCAL;
         cfg_ff.line_width   <= d2p_pkg::RESET_LINE_WIDTH;
         cfg_ff.min_depth_mm <= d2p_pkg::RESET_MIN_DEPTH;
      end else if (csr_write_en) begin
         case (csr_index)
            d2p_pkg::CSR_PRINCIPAL_X: cfg_ff.principal_x  <= csr_data[15:0];
            d2p_pkg::CSR_PRINCIPAL_Y: cfg_ff.principal_y  <= csr_data[15:0];
            d2p_pkg::CSR_INV_FOCAL_X: cfg_ff.inv_focal_x  <= csr_data;
            d2p_pkg::CSR_INV_FOCAL_Y: cfg_ff.inv_focal_y  <= csr_data;
            d2p_pkg::CSR_LINE_WIDTH:  cfg_ff.line_width   <= csr_data[12:0];
            d2p_pkg::CSR_MIN_DEPTH:   cfg_ff.min_depth_mm <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   assign full   = q_full;
   assign accept = push && !q_full;

   d2p_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .accept      (accept),
      .frame_start (req_frame_start),
      .depth_mm    (req_depth_mm),
      .blue        (req_blue),
      .green       (req_green),
      .red         (req_red),
      .item        (front_item)
   );

   d2p_queue #(
      .DEPTH (4)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept),
      .wr_data (front_item),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_data (q_data),
      .empty   (q_empty)
   );

   d2p_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .q_empty      (q_empty),
      .q_data       (q_data),
      .q_pop        (q_pop),
      .pop          (pop),
      .empty        (empty),
      .x_mm         (rsp_x_mm),
      .y_mm         (rsp_y_mm),
      .z_mm         (rsp_z_mm),
      .depth_valid  (rsp_depth_valid),
      .out_blue     (rsp_out_blue),
      .out_green    (rsp_out_green),
      .out_red      (rsp_out_red),
      .pixel_column (rsp_pixel_column),
      .pixel_row    (rsp_pixel_row)
   );

endmodule

>>> sim/depth_to_point_backprojection_tb.sv
`timescale 1ns / 1ps

module depth_to_point_backprojection_tb;

   localparam logic [d2p_pkg::CSR_INDEX_BITS-1:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [d2p_pkg::CSR_INDEX_BITS-1:0] CSR_UNMAPPED_HI = 3'd7;
   localparam logic [15:0] INVALID_DEPTH_Z = 16'd1000;
   localparam int          SPAN_LIMIT      = 4096;
   localparam logic [11:0] ROW_CEILING     = 12'hFFF;
   localparam int          FRAC_BITS       = 28;
   localparam longint      COORD_MAX       = 8388607;
   localparam longint      COORD_MIN       = -8388608;
   localparam int          STALL_LIMIT     = 500;
   localparam int          RANDOM_PHASES   = 8;
   localparam int          PHASE_PIXELS    = 180;
   localparam int          SWEEP_PIXELS    = 120;

   typedef struct packed {
      logic        start;
      logic [15:0] depth;
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
   } pixel_type;

   typedef struct packed {
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic [15:0]        z;
      logic               valid;
      logic [7:0]         blue;
      logic [7:0]         green;
      logic [7:0]         red;
      logic [11:0]        column;
      logic [11:0]        row;
   } point_type;

   typedef struct packed {
      logic                               is_write;
      logic [d2p_pkg::CSR_INDEX_BITS-1:0] index;
      logic [d2p_pkg::CSR_DATA_BITS-1:0]  data;
      pixel_type                          px;
      logic                               typed;
      point_type                          golden;
   } step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   logic req_frame_start = 1'b0;
   logic [15:0] req_depth_mm = '0;
   logic [7:0] req_blue = '0;
   logic [7:0] req_green = '0;
   logic [7:0] req_red = '0;
   logic empty;
   logic pop = 1'b0;
   logic signed [23:0] rsp_x_mm;
   logic signed [23:0] rsp_y_mm;
   logic [15:0] rsp_z_mm;
   logic rsp_depth_valid;
   logic [7:0] rsp_out_blue;
   logic [7:0] rsp_out_green;
   logic [7:0] rsp_out_red;
   logic [11:0] rsp_pixel_column;
   logic [11:0] rsp_pixel_row;
   logic csr_write_en = 1'b0;
   logic [d2p_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [d2p_pkg::CSR_DATA_BITS-1:0] csr_data = '0;

   d2p_pkg::cfg_type cal;
   logic [11:0] column_at;
   logic [11:0] row_at;
   point_type pending_points[$];
   step_type plan[$];
   point_type no_golden;
   bit in_flight = 1'b0;
   int send_idle_pct = 0;
   int pop_idle_pct = 0;
   int pop_hold = 0;
   int stall_cycles = 0;
   int mismatches = 0;
   int pixels_sent = 0;
   int points_checked = 0;
   int writes_done = 0;

   depth_to_point_backprojection dut (.*);

   always #2 clock = ~clock;

   function automatic logic signed [23:0] to_coord(logic [11:0] pos, logic [15:0] centre,
                                                   logic [15:0] z, logic [23:0] inv);
      longint offset, prod, q;
      offset = longint'(pos) * 16 - longint'(centre);
      prod = offset * longint'(z) * longint'(inv);
      q = prod >>> FRAC_BITS;
      if (q > COORD_MAX) q = COORD_MAX;
      else if (q < COORD_MIN) q = COORD_MIN;
      return q[23:0];
   endfunction

   function automatic point_type backproject(pixel_type px);
      point_type pt;
      logic [15:0] zcalc;
      int span;
      if (px.start) begin
         column_at = '0;
         row_at = '0;
      end
      pt.valid = px.depth > cal.min_depth_mm;
      zcalc = pt.valid ? px.depth : INVALID_DEPTH_Z;
      pt.z = pt.valid ? px.depth : 16'd0;
      pt.x = to_coord(column_at, cal.principal_x, zcalc, cal.inv_focal_x);
      pt.y = to_coord(row_at, cal.principal_y, zcalc, cal.inv_focal_y);
      pt.blue = px.blue;
      pt.green = px.green;
      pt.red = px.red;
      pt.column = column_at;
      pt.row = row_at;
      span = int'(cal.line_width);
      if (span == 0) span = 1;
      if (span > SPAN_LIMIT) span = SPAN_LIMIT;
      if (int'(column_at) + 1 >= span) begin
         column_at = '0;
         if (row_at != ROW_CEILING) row_at = row_at + 1'b1;
      end else begin
         column_at = column_at + 1'b1;
      end
      return pt;
   endfunction

   function automatic pixel_type random_pixel(bit start);
      pixel_type px;
      px.start = start;
      case ($urandom_range(0, 9))
         0: px.depth = 16'd0;
         1: px.depth = cal.min_depth_mm;
         2: px.depth = cal.min_depth_mm + 16'd1;
         3: px.depth = cal.min_depth_mm - 16'd1;
         4: px.depth = 16'hFFFF;
         5: px.depth = 16'($urandom_range(1, 16));
         default: px.depth = 16'($urandom);
      endcase
      px.blue = 8'($urandom);
      px.green = 8'($urandom);
      px.red = 8'($urandom);
      return px;
   endfunction

   function automatic void plan_write(logic [d2p_pkg::CSR_INDEX_BITS-1:0] index,
                                      logic [d2p_pkg::CSR_DATA_BITS-1:0] data);
      step_type s;
      s = '0;
      s.is_write = 1'b1;
      s.index = index;
      s.data = data;
      plan = {plan, s};
   endfunction

   function automatic void plan_pixel(bit start, logic [15:0] depth,
                                      logic [7:0] b, logic [7:0] g, logic [7:0] r);
      step_type s;
      s = '0;
      s.px = '{start, depth, b, g, r};
      plan = {plan, s};
   endfunction

   function automatic void plan_typed(bit start, logic [15:0] depth,
                                      logic [7:0] b, logic [7:0] g, logic [7:0] r,
                                      int x, int y, logic [15:0] z, bit valid, int col, int row);
      plan_pixel(start, depth, b, g, r);
      plan[$].typed = 1'b1;
      plan[$].golden = '{x[23:0], y[23:0], z, valid, b, g, r, col[11:0], row[11:0]};
   endfunction

   task automatic check_field(string field, logic signed [63:0] want, logic signed [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endtask

   // drop push and wait for the pipeline to drain before touching registers
   task automatic settle();
      if (in_flight) begin
         push <= 1'b0;
         while (pending_points.size() != 0) @(posedge clock);
         repeat (6) @(posedge clock);
         in_flight = 1'b0;
      end
   endtask

   task automatic write_reg(logic [d2p_pkg::CSR_INDEX_BITS-1:0] index,
                            logic [d2p_pkg::CSR_DATA_BITS-1:0] data);
      settle();
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      case (index)
         d2p_pkg::CSR_PRINCIPAL_X: cal.principal_x = data[15:0];
         d2p_pkg::CSR_PRINCIPAL_Y: cal.principal_y = data[15:0];
         d2p_pkg::CSR_INV_FOCAL_X: cal.inv_focal_x = data[23:0];
         d2p_pkg::CSR_INV_FOCAL_Y: cal.inv_focal_y = data[23:0];
         d2p_pkg::CSR_LINE_WIDTH:  cal.line_width = data[12:0];
         d2p_pkg::CSR_MIN_DEPTH:   cal.min_depth_mm = data[15:0];
         default: ;
      endcase
      writes_done++;
   endtask

   task automatic send_pixel(pixel_type px, bit typed, point_type golden);
      point_type pt;
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         push <= 1'b0;
         csr_write_en <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      push <= 1'b1;
      csr_write_en <= 1'b0;
      req_frame_start <= px.start;
      req_depth_mm <= px.depth;
      req_blue <= px.blue;
      req_green <= px.green;
      req_red <= px.red;
      do @(posedge clock); while (!(push && !full));
      pt = backproject(px);
      pending_points = {pending_points, (typed ? golden : pt)};
      in_flight = 1'b1;
      pixels_sent++;
   endtask

   task automatic random_calibration();
      logic [d2p_pkg::CSR_DATA_BITS-1:0] value;
      for (int idx = 0; idx <= int'(d2p_pkg::CSR_MIN_DEPTH); idx++) begin
         value = 24'($urandom);
         case (idx)
            d2p_pkg::CSR_PRINCIPAL_X, d2p_pkg::CSR_PRINCIPAL_Y, d2p_pkg::CSR_MIN_DEPTH:
               case ($urandom_range(0, 3))
                  0: value[15:0] = 16'h0000;
                  1: value[15:0] = 16'hFFFF;
                  2: ;
                  default: value[15:0] = 16'($urandom_range(0, 12000));
               endcase
            d2p_pkg::CSR_INV_FOCAL_X, d2p_pkg::CSR_INV_FOCAL_Y:
               case ($urandom_range(0, 3))
                  0: value = 24'h000000;
                  1: value = 24'hFFFFFF;
                  2: ;
                  default: value = 24'($urandom_range(8000, 80000));
               endcase
            default:
               case ($urandom_range(0, 9))
                  0: value[12:0] = 13'd0;
                  1: value[12:0] = 13'd1;
                  2: value[12:0] = 13'd4096;
                  3: value[12:0] = 13'h1FFF;
                  4, 5, 6: value[12:0] = 13'($urandom_range(2, 16));
                  7: value[12:0] = 13'($urandom_range(17, 64));
                  8: value[12:0] = 13'($urandom_range(1, 8191));
                  default: value[12:0] = 13'd640;
               endcase
         endcase
         write_reg(idx[d2p_pkg::CSR_INDEX_BITS-1:0], value);
      end
      if ($urandom_range(0, 2) == 0)
         write_reg($urandom_range(0, 1) ? CSR_UNMAPPED_LO : CSR_UNMAPPED_HI, 24'($urandom));
   endtask

   always @(posedge clock) begin
      if (pop_hold != 0) begin
         pop_hold <= pop_hold - 1;
         pop <= 1'b0;
      end else if (pop_idle_pct != 0 && $urandom_range(0, 99) < pop_idle_pct) begin
         pop_hold <= $urandom_range(0, 10);
         pop <= 1'b0;
      end else begin
         pop <= 1'b1;
      end
   end

   always @(posedge clock) begin
      point_type want;
      if (!reset) begin
         if ((push && !full) || (pop && !empty)) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("depth_to_point_backprojection_tb NOT OK");
            $finish;
         end else if (pop && !empty) begin
            if (pending_points.size() == 0) begin
               $error("point word popped with none expected");
               mismatches++;
            end else begin
               want = pending_points.pop_front();
               check_field("x_mm", want.x, rsp_x_mm);
               check_field("y_mm", want.y, rsp_y_mm);
               check_field("z_mm", want.z, rsp_z_mm);
               check_field("depth_valid", want.valid, rsp_depth_valid);
               check_field("out_blue", want.blue, rsp_out_blue);
               check_field("out_green", want.green, rsp_out_green);
               check_field("out_red", want.red, rsp_out_red);
               check_field("pixel_column", want.column, rsp_pixel_column);
               check_field("pixel_row", want.row, rsp_pixel_row);
               points_checked++;
            end
         end
      end
   end

   initial begin
      cal.principal_x = 16'd5112;
      cal.principal_y = 16'd3832;
      cal.inv_focal_x = 24'd31957;
      cal.inv_focal_y = 24'd31957;
      cal.line_width = 13'd640;
      cal.min_depth_mm = 16'd100;
      column_at = '0;
      row_at = '0;
      no_golden = '0;

      // defaults, then depth at and around the minimum
      plan_typed(1, 16'd0, 8'h00, 8'h00, 8'h00, -609, -457, 16'd0, 0, 0, 0);
      plan_pixel(0, 16'd100, 8'hFF, 8'hFF, 8'hFF);
      plan_pixel(0, 16'd101, 8'h5A, 8'hA5, 8'h3C);
      plan_pixel(0, 16'hFFFF, 8'hA5, 8'h5A, 8'hC3);
      // zero width acts as one; column already past it wraps
      plan_write(d2p_pkg::CSR_LINE_WIDTH, 24'd0);
      plan_pixel(0, 16'h8000, 8'h01, 8'h80, 8'h7F);
      plan_pixel(0, 16'h7FFF, 8'hFE, 8'h02, 8'h40);
      plan_write(d2p_pkg::CSR_LINE_WIDTH, 24'd3);
      plan_pixel(0, 16'd1000, 8'h10, 8'h20, 8'h30);
      plan_pixel(0, 16'd1001, 8'h40, 8'h50, 8'h60);
      plan_pixel(0, 16'd1002, 8'h70, 8'h80, 8'h90);
      // zero reciprocal focal length pins x and y to zero
      plan_write(d2p_pkg::CSR_INV_FOCAL_X, 24'd0);
      plan_write(d2p_pkg::CSR_INV_FOCAL_Y, 24'd0);
      plan_typed(1, 16'd500, 8'h11, 8'h22, 8'h33, 0, 0, 16'd500, 1, 0, 0);
      plan_write(d2p_pkg::CSR_MIN_DEPTH, 24'h00FFFF);
      plan_typed(0, 16'hFFFF, 8'h44, 8'h55, 8'h66, 0, 0, 16'd0, 0, 1, 0);
      plan_write(d2p_pkg::CSR_MIN_DEPTH, 24'd0);
      plan_typed(0, 16'd0, 8'h77, 8'h88, 8'h99, 0, 0, 16'd0, 0, 2, 0);
      plan_typed(0, 16'd1, 8'hAA, 8'hBB, 8'hCC, 0, 0, 16'd1, 1, 0, 1);
      // full-scale calibration drives x into saturation
      plan_write(d2p_pkg::CSR_INV_FOCAL_X, 24'hFFFFFF);
      plan_write(d2p_pkg::CSR_INV_FOCAL_Y, 24'hFFFFFF);
      plan_write(d2p_pkg::CSR_PRINCIPAL_X, 24'h00FFFF);
      plan_write(d2p_pkg::CSR_PRINCIPAL_Y, 24'd0);
      plan_write(d2p_pkg::CSR_LINE_WIDTH, 24'h001FFF);
      plan_typed(1, 16'hFFFF, 8'hFF, 8'h00, 8'hFF, -8388608, 0, 16'hFFFF, 1, 0, 0);
      plan_pixel(0, 16'hFFFF, 8'h00, 8'hFF, 8'h00);
      plan_write(d2p_pkg::CSR_PRINCIPAL_X, 24'd0);
      plan_typed(1, 16'hFFFF, 8'h0F, 8'hF0, 8'h0F, 0, 0, 16'hFFFF, 1, 0, 0);
      plan_pixel(0, 16'hFFFF, 8'hF0, 8'h0F, 8'hF0);
      plan_write(CSR_UNMAPPED_LO, 24'hFFFFFF);
      plan_write(CSR_UNMAPPED_HI, 24'h000001);
      plan_pixel(0, 16'd2000, 8'h3C, 8'hC3, 8'h96);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 20;
      pop_idle_pct = 20;
      foreach (plan[i]) begin
         if (plan[i].is_write) write_reg(plan[i].index, plan[i].data);
         else send_pixel(plan[i].px, plan[i].typed, plan[i].golden);
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         random_calibration();
         send_idle_pct = $urandom_range(0, 2) * 20;
         pop_idle_pct = $urandom_range(0, 2) * 20;
         for (int k = 0; k < PHASE_PIXELS; k++)
            send_pixel(random_pixel(k == 0 || $urandom_range(0, 99) < 2), 0, no_golden);
      end

      // oversize width clamps to the 4096-pixel maximum; no wrap in this stretch
      send_idle_pct = 0;
      pop_idle_pct = 0;
      write_reg(d2p_pkg::CSR_LINE_WIDTH, 24'h001FFF);
      for (int k = 0; k < SWEEP_PIXELS; k++) send_pixel(random_pixel(k == 0), 0, no_golden);
      // one pixel per row: row advances on every pixel
      write_reg(d2p_pkg::CSR_LINE_WIDTH, 24'hFFE001);
      for (int k = 0; k < SWEEP_PIXELS; k++) send_pixel(random_pixel(k == 0), 0, no_golden);

      settle();
      repeat (10) @(posedge clock);
      $display("%0d pixels sent, %0d points checked, %0d register writes",
               pixels_sent, points_checked, writes_done);
      $display("covered invalid and saturated depths, zero and oversize widths, %s",
               "mid-row width changes and random calibration under stalls");
      if (mismatches == 0) begin
         $display("depth_to_point_backprojection_tb OK");
      end else begin
         $display("depth_to_point_backprojection_tb NOT OK");
      end
      $finish;
   end

endmodule
